// ----- hw/rtl/mcssr_pkg.sv -----
// shared types and constants for the multi-channel soft-start ramp
`timescale 1ns / 1ps

package mcssr_pkg;

    localparam int CHANNELS_DEF  = 6;
    localparam int FRAC_BITS_DEF = 16;
    localparam int TIME_W        = 32;
    localparam int CHAN_W        = 3;

    // command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_RESET  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_DIV  = 4'b0100,
        S_PUT  = 4'b1000
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;   // latch the input transfer
        logic load;      // update channel state, compute elapsed, seed result
        logic step;      // one restoring division step
        logic put;       // move the result into the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_reset;  // latched command is a channel reset
        logic early;     // result known without division
        logic last;      // final division step
        logic out_busy;  // output register holds a result that is not taken
    } t_dp_sts;

endpackage

// ----- hw/rtl/mcssr_dp.sv -----
// datapath: channel flags, start times, restoring divider and output register
`timescale 1ns / 1ps

module mcssr_dp
    import mcssr_pkg::*;
#(
    parameter int CHANNELS  = CHANNELS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  logic                 i_command,
    input  logic [CHAN_W-1:0]    i_channel,
    input  logic [TIME_W-1:0]    i_duration_us,
    input  logic [TIME_W-1:0]    i_now_us,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [FRAC_BITS:0]   o_fraction
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W = $clog2(FRAC_BITS + 1);
    localparam logic [FRAC_BITS:0]   FULL     = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [CNT_W-1:0]     LAST_CNT = CNT_W'(FRAC_BITS - 1);
    localparam logic [CHAN_W:0]      NUM_CH   = (CHAN_W + 1)'(CHANNELS);

    // latched transfer
    logic                r_cmd;
    logic [CHAN_W-1:0]   r_chan;
    logic [TIME_W-1:0]   r_dur;
    logic [TIME_W-1:0]   r_now;

    // channel state
    logic [CHANNELS-1:0] r_started;
    logic [TIME_W-1:0]   r_start_time [CHANNELS];

    // divider
    logic [TIME_W-1:0]   r_rem;
    logic [FRAC_BITS:0]  r_res;
    logic [CNT_W-1:0]    r_cnt;

    // output register
    logic                r_out_valid;
    logic [FRAC_BITS:0]  r_out_frac;

    logic                chan_ok;
    logic [IDX_W-1:0]    idx;
    logic                cur_started;
    logic [TIME_W-1:0]   base_time;
    logic [TIME_W-1:0]   elapsed;
    logic                full;
    logic [TIME_W:0]     rem2;
    logic                ge;

    assign chan_ok     = {1'b0, r_chan} < NUM_CH;
    assign idx         = r_chan[IDX_W-1:0];
    assign cur_started = chan_ok && r_started[idx];
    assign base_time   = cur_started ? r_start_time[idx] : r_now;
    assign elapsed     = r_now - base_time;
    assign full        = (r_dur == '0) || (elapsed >= r_dur);

    assign rem2 = {r_rem, 1'b0};
    assign ge   = rem2 >= {1'b0, r_dur};

    assign o_sts.is_reset = (r_cmd == CMD_RESET);
    assign o_sts.early    = !chan_ok || full;
    assign o_sts.last     = (r_cnt == LAST_CNT);
    assign o_sts.out_busy = r_out_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd  <= i_command;
            r_chan <= i_channel;
            r_dur  <= i_duration_us;
            r_now  <= i_now_us;
        end
    end

    // started flags: control state, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= '0;
        end else if (i_cmd.load && chan_ok) begin
            r_started[idx] <= (r_cmd == CMD_SAMPLE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && chan_ok && (r_cmd == CMD_SAMPLE) && !r_started[idx]) begin
            r_start_time[idx] <= r_now;
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem <= elapsed;
            r_cnt <= '0;
            if (!chan_ok) begin
                r_res <= '0;
            end else if (full) begin
                r_res <= FULL;
            end else begin
                r_res <= '0;
            end
        end else if (i_cmd.step) begin
            r_rem <= ge ? TIME_W'(rem2 - {1'b0, r_dur}) : rem2[TIME_W-1:0];
            r_res <= {r_res[FRAC_BITS-1:0], ge};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.put) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            r_out_frac <= r_res;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_fraction = r_out_frac;

endmodule

// ----- hw/rtl/mcssr_ctrl.sv -----
// controller state machine for the soft-start ramp
`timescale 1ns / 1ps

module mcssr_ctrl
    import mcssr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                if (i_sts.is_reset) begin
                    n_state = S_IDLE;
                end else if (i_sts.early) begin
                    n_state = S_PUT;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_sts.last) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.put = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- hw/rtl/multi_channel_soft_start_ramp.sv -----
// top level of the multi-channel soft-start ramp generator
`timescale 1ns / 1ps
// usage
// - input channel (i_valid / o_stall) carries one command per transfer:
//   sample a channel's ramp fraction, or reset a channel so that its next
//   sample latches i_now_us as the new start time
// - output channel (o_valid / i_stall) carries one o_fraction per sample,
//   unsigned Q1.FRAC_BITS, full scale 1 << FRAC_BITS; reset commands give none
// - the block works on one command at a time; o_stall is high while busy,
//   so the next command waits for the load, the division steps if any and
//   the hand-off of a sample, or for the load alone after a reset
// - a sample is divided before o_valid unless its ramp is complete, its
//   duration is zero or its channel is unknown; a reset command ends after
//   the channel update and gives no o_valid
// - the restoring divider makes one quotient bit per cycle from a 33-bit
//   compare and subtract
// - the output register frees the input side: a new command is taken while
//   a result still waits; if the receiver stalls when the next result is
//   ready, the block holds that result and keeps o_stall high
// - reset (i_rst_n low, synchronous) clears all started flags and drops
//   o_valid; start times need no reset since a channel latches one first
module multi_channel_soft_start_ramp
    import mcssr_pkg::*;
#(
    parameter int CHANNELS  = CHANNELS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // command transfer
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_command,
    input  logic [CHAN_W-1:0]   i_channel,
    input  logic [TIME_W-1:0]   i_duration_us,
    input  logic [TIME_W-1:0]   i_now_us,
    // result transfer
    output logic                o_valid,
    input  logic                i_stall,
    output logic [FRAC_BITS:0]  o_fraction
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // sequencing: idle, channel update, division steps, hand-off
    mcssr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd)
    );

    // channel state, elapsed time, divider and output register
    mcssr_dp #(
        .CHANNELS  (CHANNELS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .i_command     (i_command),
        .i_channel     (i_channel),
        .i_duration_us (i_duration_us),
        .i_now_us      (i_now_us),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_fraction    (o_fraction)
    );

endmodule

// ----- tb/multi_channel_soft_start_ramp_tb.sv -----
// self-checking testbench for the multi-channel soft-start ramp generator
`timescale 1ns / 1ps

module multi_channel_soft_start_ramp_tb;
    import mcssr_pkg::*;

    localparam int CHANS      = CHANNELS_DEF;
    localparam int FB         = FRAC_BITS_DEF;
    localparam int IDLE_LIMIT = 2000;   // cycles with no transfer before giving up
    localparam int TAIL       = 40;     // settle time after the last result
    localparam int HOLD_LEN   = 300;    // long receiver hold-off
    localparam logic [FB:0] FULL_SCALE = (FB + 1)'(1 << FB);

    // clock, reset and block inputs, all known from time zero
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_command = CMD_SAMPLE;
    logic [CHAN_W-1:0] i_channel = '0;
    logic [TIME_W-1:0] i_duration_us = '0;
    logic [TIME_W-1:0] i_now_us = '0;
    logic i_stall = 1'b0;

    logic o_stall;
    logic o_valid;
    logic [FB:0] o_fraction;

    // predicted ramp state
    bit ramp_started [CHANS];
    logic [TIME_W-1:0] ramp_t0 [CHANS];
    logic [FB:0] expected_fraction_q [$];

    int err_count = 0;
    int cmds_sent = 0;
    int results_seen = 0;
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int rx_hold_cycles = 0;
    logic [TIME_W-1:0] tb_now = 32'hFFF0_0000;

    always #2 i_clk = ~i_clk;

    multi_channel_soft_start_ramp uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_channel     (i_channel),
        .i_duration_us (i_duration_us),
        .i_now_us      (i_now_us),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_fraction    (o_fraction)
    );

    function automatic int pick_gap(bit en);
        return en ? $urandom_range(0, 16) : 0;
    endfunction

    task automatic report_mismatch(string what, logic [FB:0] got, logic [FB:0] want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        err_count++;
    endtask

    // update the predicted channel state and queue the fraction a sample yields
    task automatic predict_ramp(logic cmd, logic [CHAN_W-1:0] chan,
                                logic [TIME_W-1:0] dur, logic [TIME_W-1:0] now_v);
        logic [TIME_W-1:0] elapsed;
        logic [63:0] quo;
        logic [FB:0] frac;
        if (cmd == CMD_RESET) begin
            // reset never yields a result; unknown channels are ignored
            if (chan < CHANS)
                ramp_started[chan] = 1'b0;
        end else begin
            if (chan >= CHANS) begin
                frac = '0;
            end else begin
                // first sample after reset latches the start time
                if (!ramp_started[chan]) begin
                    ramp_t0[chan] = now_v;
                    ramp_started[chan] = 1'b1;
                end
                elapsed = now_v - ramp_t0[chan];   // wraps modulo 2^32
                if (dur == '0 || elapsed >= dur) begin
                    frac = FULL_SCALE;
                end else begin
                    quo = ({32'b0, elapsed} << FB) / {32'b0, dur};
                    frac = quo[FB:0];
                end
            end
            expected_fraction_q.push_back(frac);
        end
    endtask

    // offer one command after a random gap and wait for its transfer
    task automatic send_command(logic cmd, logic [CHAN_W-1:0] chan,
                                logic [TIME_W-1:0] dur, logic [TIME_W-1:0] now_v);
        int gap;
        gap = pick_gap(tx_idle_on);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_command     <= cmd;
        i_channel     <= chan;
        i_duration_us <= dur;
        i_now_us      <= now_v;
        do @(posedge i_clk); while (o_stall);
        predict_ramp(cmd, chan, dur, now_v);
        cmds_sent++;
    endtask

    // receiver: random stalls per result, plus one long hold-off on request
    initial begin : rx_proc
        int gap;
        wait (i_rst_n);
        forever begin
            gap = pick_gap(rx_idle_on);
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                i_stall <= 1'b1;
                repeat (rx_hold_cycles) @(negedge i_clk);
                rx_hold_cycles = 0;
            end else if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // result checker: each transfer against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (expected_fraction_q.size() == 0)
                report_mismatch("unexpected fraction", o_fraction, '0);
            else if (o_fraction !== expected_fraction_q[0])
                report_mismatch("fraction", o_fraction, expected_fraction_q.pop_front());
            else
                void'(expected_fraction_q.pop_front());
        end
    end

    // watchdog on cycles without any transfer
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("multi_channel_soft_start_ramp_tb: FAIL");
        $finish;
    end

    // start, mid-ramp, exact end, past end, zero duration and the 0/0 first sample
    task automatic test_ramp_basics;
        send_command(CMD_SAMPLE, 3'd0, 32'd1000, 32'd5000);
        send_command(CMD_SAMPLE, 3'd0, 32'd1000, 32'd5500);
        send_command(CMD_SAMPLE, 3'd0, 32'd1000, 32'd6000);
        send_command(CMD_SAMPLE, 3'd0, 32'd1000, 32'd9000);
        send_command(CMD_SAMPLE, 3'd0, 32'd0, 32'd5001);
        send_command(CMD_SAMPLE, 3'd1, 32'd0, 32'd0);
    endtask

    task automatic test_unknown_channel;
        send_command(CMD_SAMPLE, 3'd6, 32'd500, 32'd123);
        send_command(CMD_SAMPLE, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(CMD_RESET, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_channel_reset;
        send_command(CMD_RESET, 3'd0, 32'd0, 32'd0);
        send_command(CMD_SAMPLE, 3'd0, 32'd100, 32'd7);
    endtask

    task automatic test_timer_wrap;
        send_command(CMD_RESET, 3'd2, 32'd0, 32'd0);
        send_command(CMD_SAMPLE, 3'd2, 32'h0000_1000, 32'hFFFF_FF00);
        send_command(CMD_SAMPLE, 3'd2, 32'h0000_1000, 32'h0000_0100);
    endtask

    task automatic test_duration_extremes;
        send_command(CMD_SAMPLE, 3'd3, 32'hFFFF_FFFF, 32'd0);
        send_command(CMD_SAMPLE, 3'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_command(CMD_SAMPLE, 3'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(CMD_SAMPLE, 3'd4, 32'd1, 32'd10);
        send_command(CMD_SAMPLE, 3'd4, 32'd1, 32'd11);
        send_command(CMD_SAMPLE, 3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(CMD_RESET, 3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // receiver holds off while samples keep coming, so the block backs up
    task automatic test_output_hold;
        int k;
        tx_idle_on = 1'b0;
        rx_hold_cycles = HOLD_LEN;
        for (k = 0; k < 12; k++) begin
            tb_now += $urandom_range(0, 500);
            send_command(CMD_SAMPLE, 3'(k % CHANS), $urandom_range(1, 20000), tb_now);
        end
        tx_idle_on = 1'b1;
    endtask

    // mostly well-formed ramps on a slowly advancing timer that crosses the wrap
    task automatic test_random_traffic(int n);
        int i;
        int r;
        int d;
        logic cmd;
        logic [CHAN_W-1:0] chan;
        logic [TIME_W-1:0] dur;
        logic [TIME_W-1:0] now_v;
        for (i = 0; i < n; i++) begin
            if (i % 150 == 0) begin
                case ((i / 150) % 4)
                    0: begin tx_idle_on = 1'b1; rx_idle_on = 1'b1; end
                    1: begin tx_idle_on = 1'b0; rx_idle_on = 1'b0; end
                    2: begin tx_idle_on = 1'b1; rx_idle_on = 1'b0; end
                    default: begin tx_idle_on = 1'b0; rx_idle_on = 1'b1; end
                endcase
            end
            r = $urandom_range(0, 99);
            if (r == 0)
                tb_now = $urandom();
            else
                tb_now += $urandom_range(0, 3000);
            d = $urandom_range(0, 99);
            if (d < 4)
                dur = '0;
            else if (d < 20)
                dur = $urandom_range(1, 64);
            else if (d < 75)
                dur = $urandom_range(1000, 200000);
            else if (d < 92)
                dur = $urandom();
            else
                dur = 32'hFFFF_FFFF;
            now_v = ($urandom_range(0, 19) == 0) ? $urandom() : tb_now;
            cmd = CMD_SAMPLE;
            chan = CHAN_W'($urandom_range(0, CHANS - 1));
            if (r >= 90) begin
                cmd = CMD_RESET;
                chan = CHAN_W'($urandom_range(0, 7));
            end else if (r >= 84) begin
                chan = CHAN_W'($urandom_range(CHANS, 7));
            end
            send_command(cmd, chan, dur, now_v);
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin : main
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_ramp_basics();
        test_unknown_channel();
        test_channel_reset();
        test_timer_wrap();
        test_duration_extremes();
        test_output_hold();
        test_random_traffic(1420);

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_fraction_q.size() != 0) @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);

        $display("covered %0d commands and %0d checked fractions: ramp edges, zero duration,",
                 cmds_sent, results_seen);
        $display("unknown channels, channel resets, timer wrap, long output hold; %0d mismatches",
                 err_count);
        if (err_count == 0)
            $display("multi_channel_soft_start_ramp_tb: PASS");
        else
            $display("multi_channel_soft_start_ramp_tb: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/mcssr_pkg.sv
hw/rtl/mcssr_dp.sv
hw/rtl/mcssr_ctrl.sv
hw/rtl/multi_channel_soft_start_ramp.sv
tb/multi_channel_soft_start_ramp_tb.sv
